// ----- hw/rtl/cache_hit_miss_tag_store_unit_assert.svh -----
// assertion macros for the cache tag store unit
// implication and next-cycle forms, compiled out when SYNTH is defined
`ifndef CACHE_HIT_MISS_TAG_STORE_UNIT_ASSERT_SVH
`define CACHE_HIT_MISS_TAG_STORE_UNIT_ASSERT_SVH

`ifndef SYNTH
`define CHMS_ASSERT_IMPL(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("chms assertion failed");
`define CHMS_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("chms assertion failed");
`else
`define CHMS_ASSERT_IMPL(name, clk, rst, ante, cons)
`define CHMS_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif

`endif

// ----- hw/rtl/chms_pkg.sv -----
// shared constants and types for the cache tag store unit
// no dependencies
`timescale 1ns / 1ps

package chms_pkg;

   localparam int ADDR_W   = 32;
   localparam int MAX_SETS = 1024;
   localparam int SET_W    = 10;
   localparam int MAX_WAYS = 4;
   localparam int WAY_W    = 2;
   localparam int TAG_W    = 32;
   localparam int CNT_W    = 32;
   localparam int LFSR_W   = 16;
   localparam int SHIFT_W  = 5;
   localparam int CSR_W    = 16;

   localparam logic [LFSR_W-1:0] LFSR_POLY = 16'hB400;
   localparam logic [LFSR_W-1:0] LFSR_ONE  = 16'h0001;

   localparam logic [1:0] WAYS_LOG2_MAX = 2'd2;
   localparam logic [3:0] SET_BITS_MAX  = 4'd10;

   localparam logic [1:0] CSR_WAYS_LOG2   = 2'd0;
   localparam logic [1:0] CSR_OFFSET_BITS = 2'd1;
   localparam logic [1:0] CSR_SET_BITS    = 2'd2;
   localparam logic [1:0] CSR_LFSR_SEED   = 2'd3;

   typedef struct packed {
      logic             valid;
      logic [TAG_W-1:0] tag;
   } entry_type;

   typedef struct packed {
      logic              load;
      logic [LFSR_W-1:0] seed;
      logic              advance;
   } lfsr_ctrl_type;

endpackage

// ----- hw/rtl/chms_way_ram.sv -----
// one way of the tag store: valid bit and tag per set
// synchronous read into a registered output, one write port; uses chms_pkg
`timescale 1ns / 1ps

module chms_way_ram
   import chms_pkg::*;
(
   input  logic             clock,
   input  logic             rd_en,
   input  logic [SET_W-1:0] rd_addr,
   output entry_type        rd_data,
   input  logic             wr_en,
   input  logic [SET_W-1:0] wr_addr,
   input  entry_type        wr_data
);

   entry_type mem [MAX_SETS];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/chms_replace_lfsr.sv -----
// galois lfsr that picks the victim way on a miss
// reloaded from the seed register, advanced once per transaction; uses chms_pkg
`timescale 1ns / 1ps

module chms_replace_lfsr
   import chms_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  lfsr_ctrl_type     ctrl,
   output logic [LFSR_W-1:0] value
);

   logic [LFSR_W-1:0] lfsr_ff;
   logic [LFSR_W-1:0] lfsr_in;

   always_comb begin
      lfsr_in = lfsr_ff;
      if (ctrl.load) begin
         lfsr_in = (ctrl.seed == '0) ? LFSR_ONE : ctrl.seed;
      end else if (ctrl.advance) begin
         lfsr_in = (lfsr_ff >> 1) ^ (lfsr_ff[0] ? LFSR_POLY : '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lfsr_ff <= LFSR_ONE;
      end else begin
         lfsr_ff <= lfsr_in;
      end
   end

   assign value = lfsr_ff;

endmodule

// ----- hw/rtl/cache_hit_miss_tag_store_unit.sv -----
// set-associative tag store with pseudo-random replacement, top level
// uses chms_pkg, chms_way_ram, chms_replace_lfsr and the assertion macro header
`timescale 1ns / 1ps
`include "cache_hit_miss_tag_store_unit_assert.svh"

// Each transaction has an accept and a compare step: the accept edge reads the addressed set
// from the four way memories, and while lookup_ff is set the tags are compared, the victim
// way is written on a miss and the result register is loaded. One transaction is in flight
// at a time, so req_stall is high during the compare cycle and while a finished result is
// held by rsp_stall. After reset the valid bits of all 1024 sets are cleared by a sweep,
// one set per cycle, during which req_stall stays high; csr writes are taken during the sweep.

module cache_hit_miss_tag_store_unit
   import chms_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_write_enable,
   input  logic [1:0]        csr_index,
   input  logic [CSR_W-1:0]  csr_write_data,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [ADDR_W-1:0] req_address,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_hit,
   output logic [WAY_W-1:0]  rsp_way,
   output logic [SET_W-1:0]  rsp_set_index,
   output logic [CNT_W-1:0]  rsp_hit_count,
   output logic [CNT_W-1:0]  rsp_miss_count
);

   // configuration
   logic [1:0] ways_log2_ff;
   logic [3:0] offset_bits_ff;
   logic [3:0] set_bits_ff;

   // control
   logic             clearing_ff;
   logic [SET_W-1:0] clear_cnt_ff;
   logic             lookup_ff;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;

   // payload
   logic [TAG_W-1:0] tag_ff;
   logic [SET_W-1:0] set_ff;
   logic             rsp_hit_ff;
   logic [WAY_W-1:0] rsp_way_ff;
   logic [SET_W-1:0] rsp_set_ff;
   logic [CNT_W-1:0] hit_count_ff;
   logic [CNT_W-1:0] miss_count_ff;

   logic                req_accept;
   logic [1:0]          ways_sat;
   logic [3:0]          set_bits_sat;
   logic [MAX_WAYS-1:0] way_en;
   logic [WAY_W-1:0]    way_mask;
   logic [ADDR_W-1:0]   addr_shifted;
   logic [SET_W-1:0]    set_mask;
   logic [SET_W-1:0]    req_set;
   logic [SHIFT_W-1:0]  tag_shift;
   logic [TAG_W-1:0]    req_tag;

   entry_type           rd_data [MAX_WAYS];
   logic [MAX_WAYS-1:0] match;
   logic                hit_any;
   logic [WAY_W-1:0]    hit_way;
   logic [WAY_W-1:0]    fill_way;
   logic [MAX_WAYS-1:0] wr_en;
   logic [SET_W-1:0]    wr_addr;
   entry_type           wr_data;

   lfsr_ctrl_type       lfsr_ctrl;
   logic [LFSR_W-1:0]   lfsr_value;

   assign req_stall  = clearing_ff || lookup_ff || (rsp_valid_ff && rsp_stall);
   assign req_accept = req_valid && !req_stall;

   // geometry
   always_comb begin
      ways_sat     = (ways_log2_ff > WAYS_LOG2_MAX) ? WAYS_LOG2_MAX : ways_log2_ff;
      set_bits_sat = (set_bits_ff > SET_BITS_MAX) ? SET_BITS_MAX : set_bits_ff;
      unique case (ways_sat)
         2'd0: begin
            way_en   = 4'b0001;
            way_mask = 2'b00;
         end
         2'd1: begin
            way_en   = 4'b0011;
            way_mask = 2'b01;
         end
         default: begin
            way_en   = 4'b1111;
            way_mask = 2'b11;
         end
      endcase
   end

   // address split
   always_comb begin
      addr_shifted = req_address >> offset_bits_ff;
      set_mask     = ~({SET_W{1'b1}} << set_bits_sat);
      req_set      = addr_shifted[SET_W-1:0] & set_mask;
      tag_shift    = {1'b0, offset_bits_ff} + {1'b0, set_bits_sat};
      req_tag      = req_address >> tag_shift;
   end

   // tag compare
   always_comb begin
      for (int w = 0; w < MAX_WAYS; w++) begin
         match[w] = way_en[w] && rd_data[w].valid && (rd_data[w].tag == tag_ff);
      end
      hit_any = |match;
      hit_way = '0;
      for (int w = MAX_WAYS - 1; w >= 0; w--) begin
         if (match[w]) begin
            hit_way = WAY_W'(w);
         end
      end
      fill_way = lfsr_value[WAY_W-1:0] & way_mask;
   end

   // write back on a miss, or the clearing sweep
   always_comb begin
      for (int w = 0; w < MAX_WAYS; w++) begin
         wr_en[w] = clearing_ff || (lookup_ff && !hit_any && (fill_way == WAY_W'(w)));
      end
      wr_addr       = clearing_ff ? clear_cnt_ff : set_ff;
      wr_data.valid = !clearing_ff;
      wr_data.tag   = clearing_ff ? '0 : tag_ff;
   end

   for (genvar g = 0; g < MAX_WAYS; g++) begin : g_way
      chms_way_ram u_way_ram (
         .clock   (clock),
         .rd_en   (req_accept),
         .rd_addr (req_set),
         .rd_data (rd_data[g]),
         .wr_en   (wr_en[g]),
         .wr_addr (wr_addr),
         .wr_data (wr_data)
      );
   end

   always_comb begin
      lfsr_ctrl.load    = csr_write_enable && (csr_index == CSR_LFSR_SEED);
      lfsr_ctrl.seed    = csr_write_data;
      lfsr_ctrl.advance = lookup_ff;
   end

   chms_replace_lfsr u_replace_lfsr (
      .clock (clock),
      .reset (reset),
      .ctrl  (lfsr_ctrl),
      .value (lfsr_value)
   );

   // csr writes
   always_ff @(posedge clock) begin
      if (reset) begin
         ways_log2_ff   <= 2'd0;
         offset_bits_ff <= 4'd4;
         set_bits_ff    <= 4'd10;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_WAYS_LOG2:   ways_log2_ff   <= csr_write_data[1:0];
            CSR_OFFSET_BITS: offset_bits_ff <= csr_write_data[3:0];
            CSR_SET_BITS:    set_bits_ff    <= csr_write_data[3:0];
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid_in = lookup_ff || (rsp_valid_ff && rsp_stall);

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff   <= 1'b1;
         clear_cnt_ff  <= '0;
         lookup_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         hit_count_ff  <= '0;
         miss_count_ff <= '0;
      end else begin
         if (clearing_ff) begin
            clear_cnt_ff <= clear_cnt_ff + 1'b1;
            if (clear_cnt_ff == SET_W'(MAX_SETS - 1)) begin
               clearing_ff <= 1'b0;
            end
         end
         lookup_ff    <= req_accept;
         rsp_valid_ff <= rsp_valid_in;
         if (lookup_ff) begin
            if (hit_any) begin
               if (hit_count_ff != '1) begin
                  hit_count_ff <= hit_count_ff + 1'b1;
               end
            end else if (miss_count_ff != '1) begin
               miss_count_ff <= miss_count_ff + 1'b1;
            end
         end
      end
   end

   // transaction payload
   always_ff @(posedge clock) begin
      if (req_accept) begin
         tag_ff <= req_tag;
         set_ff <= req_set;
      end
      if (lookup_ff) begin
         rsp_hit_ff <= hit_any;
         rsp_way_ff <= hit_any ? hit_way : fill_way;
         rsp_set_ff <= set_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hit        = rsp_hit_ff;
   assign rsp_way        = rsp_way_ff;
   assign rsp_set_index  = rsp_set_ff;
   assign rsp_hit_count  = hit_count_ff;
   assign rsp_miss_count = miss_count_ff;

   `CHMS_ASSERT_NEXT(a_accept_starts_lookup, clock, reset, req_accept, lookup_ff)
   `CHMS_ASSERT_IMPL(a_lookup_has_room, clock, reset, lookup_ff, !(rsp_valid_ff && rsp_stall))
   `CHMS_ASSERT_NEXT(a_lookup_gives_result, clock, reset, lookup_ff, rsp_valid_ff)
   `CHMS_ASSERT_IMPL(a_no_lookup_while_clearing, clock, reset, clearing_ff, !lookup_ff)

endmodule

// ----- verif/chms_lookup_checker.sv -----
// lookup checker for the cache tag store unit: predicts hit, way, set and counts
// for each accepted address and compares them with the response channel
// depends on chms_pkg
`timescale 1ns / 1ps

module chms_lookup_checker
   import chms_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_write_enable,
   input  logic [1:0]        csr_index,
   input  logic [CSR_W-1:0]  csr_write_data,
   input  logic              req_valid,
   input  logic              req_stall,
   input  logic [ADDR_W-1:0] req_address,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  logic              rsp_hit,
   input  logic [WAY_W-1:0]  rsp_way,
   input  logic [SET_W-1:0]  rsp_set_index,
   input  logic [CNT_W-1:0]  rsp_hit_count,
   input  logic [CNT_W-1:0]  rsp_miss_count,
   output int                mismatches,
   output int                pending,
   output int                lookups_checked,
   output int                hits_checked
);

   typedef struct packed {
      logic             hit;
      logic [WAY_W-1:0] way;
      logic [SET_W-1:0] set_index;
      logic [CNT_W-1:0] hit_count;
      logic [CNT_W-1:0] miss_count;
   } lookup_result_type;

   logic [TAG_W-1:0]  tag_mem   [MAX_SETS][MAX_WAYS];
   logic              valid_mem [MAX_SETS][MAX_WAYS];
   logic [1:0]        cfg_ways_log2;
   logic [3:0]        cfg_offset_bits;
   logic [3:0]        cfg_set_bits;
   logic [LFSR_W-1:0] victim_lfsr;
   logic [CNT_W-1:0]  hit_total;
   logic [CNT_W-1:0]  miss_total;
   lookup_result_type expected_lookups [$];

   function automatic lookup_result_type predict_lookup(input logic [ADDR_W-1:0] address);
      lookup_result_type res;
      logic [1:0]        wl;
      logic [3:0]        sb;
      int                nways;
      int                tag_shift;
      logic [SET_W-1:0]  set_sel;
      logic [TAG_W-1:0]  tag;
      logic [WAY_W-1:0]  victim;
      wl = (cfg_ways_log2 > WAYS_LOG2_MAX) ? WAYS_LOG2_MAX : cfg_ways_log2;
      sb = (cfg_set_bits > SET_BITS_MAX) ? SET_BITS_MAX : cfg_set_bits;
      nways = 1 << wl;
      set_sel = SET_W'((address >> cfg_offset_bits) & ((32'd1 << sb) - 32'd1));
      tag_shift = int'(cfg_offset_bits) + int'(sb);
      tag = TAG_W'(address >> tag_shift);
      res = '0;
      for (int w = 0; w < nways; w++) begin
         if (!res.hit && valid_mem[set_sel][w] && tag_mem[set_sel][w] == tag) begin
            res.hit = 1'b1;
            res.way = WAY_W'(w);
         end
      end
      // victim comes from the generator value before it steps
      victim = WAY_W'(victim_lfsr & LFSR_W'(nways - 1));
      victim_lfsr = victim_lfsr[0] ? ((victim_lfsr >> 1) ^ LFSR_POLY) : (victim_lfsr >> 1);
      if (res.hit) begin
         if (hit_total != '1) hit_total++;
      end else begin
         res.way = victim;
         tag_mem[set_sel][victim] = tag;
         valid_mem[set_sel][victim] = 1'b1;
         if (miss_total != '1) miss_total++;
      end
      res.set_index = set_sel;
      res.hit_count = hit_total;
      res.miss_count = miss_total;
      return res;
   endfunction

   task automatic report_mismatch(input string msg);
      mismatches++;
      if (mismatches <= 100) $display("[%0t] mismatch: %s", $time, msg);
   endtask

   always @(posedge clock) begin
      lookup_result_type want;
      if (reset) begin
         foreach (valid_mem[s, w]) valid_mem[s][w] = 1'b0;
         cfg_ways_log2 = 2'd0;
         cfg_offset_bits = 4'd4;
         cfg_set_bits = 4'd10;
         victim_lfsr = LFSR_ONE;
         hit_total = '0;
         miss_total = '0;
         expected_lookups.delete();
         mismatches = 0;
         lookups_checked = 0;
         hits_checked = 0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_WAYS_LOG2:   cfg_ways_log2 = csr_write_data[1:0];
               CSR_OFFSET_BITS: cfg_offset_bits = csr_write_data[3:0];
               CSR_SET_BITS:    cfg_set_bits = csr_write_data[3:0];
               CSR_LFSR_SEED: begin
                  // a zero seed would lock the generator
                  victim_lfsr = (csr_write_data == '0) ? LFSR_ONE : LFSR_W'(csr_write_data);
               end
               default: ;
            endcase
         end
         if (req_valid && !req_stall) expected_lookups.push_back(predict_lookup(req_address));
         if (rsp_valid && !rsp_stall) begin
            if (expected_lookups.size() == 0) begin
               report_mismatch("response transaction with no lookup outstanding");
            end else begin
               want = expected_lookups.pop_front();
               lookups_checked++;
               if (rsp_hit) hits_checked++;
               if (rsp_hit !== want.hit)
                  report_mismatch($sformatf("hit expected %0d got %0d", want.hit, rsp_hit));
               if (rsp_way !== want.way)
                  report_mismatch($sformatf("way expected %0d got %0d", want.way, rsp_way));
               if (rsp_set_index !== want.set_index)
                  report_mismatch($sformatf("set_index expected %0d got %0d",
                                            want.set_index, rsp_set_index));
               if (rsp_hit_count !== want.hit_count)
                  report_mismatch($sformatf("hit_count expected %0d got %0d",
                                            want.hit_count, rsp_hit_count));
               if (rsp_miss_count !== want.miss_count)
                  report_mismatch($sformatf("miss_count expected %0d got %0d",
                                            want.miss_count, rsp_miss_count));
            end
         end
      end
      pending = expected_lookups.size();
   end

endmodule

// ----- verif/tb_top.sv -----
// top of the cache tag store unit testbench: clock, reset, address stimulus,
// csr setup, response stalls and the final verdict
// depends on chms_pkg, chms_lookup_checker and cache_hit_miss_tag_store_unit
`timescale 1ns / 1ps

module tb_top;
   import chms_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_CYCLES = 150;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              csr_write_enable = 1'b0;
   logic [1:0]        csr_index = CSR_WAYS_LOG2;
   logic [CSR_W-1:0]  csr_write_data = '0;
   logic              req_valid = 1'b0;
   logic [ADDR_W-1:0] req_address = '0;
   logic              rsp_stall = 1'b0;
   logic              req_stall;
   logic              rsp_valid;
   logic              rsp_hit;
   logic [WAY_W-1:0]  rsp_way;
   logic [SET_W-1:0]  rsp_set_index;
   logic [CNT_W-1:0]  rsp_hit_count;
   logic [CNT_W-1:0]  rsp_miss_count;

   int                mismatches;
   int                pending;
   int                lookups_checked;
   int                hits_checked;

   int                send_idle_pct = 0;
   int                rsp_stall_pct = 0;
   logic              pressure_req = 1'b0;
   logic              hold_armed = 1'b0;
   int                hold_left = 0;
   int                cycle_count = 0;
   int                geometries = 0;
   int                cur_offset = 4;
   logic [ADDR_W-1:0] hot_pool [16];

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   cache_hit_miss_tag_store_unit DUT (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_address      (req_address),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_hit          (rsp_hit),
      .rsp_way          (rsp_way),
      .rsp_set_index    (rsp_set_index),
      .rsp_hit_count    (rsp_hit_count),
      .rsp_miss_count   (rsp_miss_count)
   );

   chms_lookup_checker lookup_checker (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_address      (req_address),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_hit          (rsp_hit),
      .rsp_way          (rsp_way),
      .rsp_set_index    (rsp_set_index),
      .rsp_hit_count    (rsp_hit_count),
      .rsp_miss_count   (rsp_miss_count),
      .mismatches       (mismatches),
      .pending          (pending),
      .lookups_checked  (lookups_checked),
      .hits_checked     (hits_checked)
   );

   // response side stalls, with a long hold-off when pressure is requested
   always @(negedge clock) begin
      if (pressure_req && !hold_armed) begin
         hold_left = HOLD_CYCLES;
         hold_armed = 1'b1;
      end
      if (!pressure_req) hold_armed = 1'b0;
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d lookups outstanding", cycle_count, pending);
         $display("** cache_hit_miss_tag_store_unit: FAILED **");
         $finish;
      end
   end

   // called at a falling edge, returns at a falling edge
   task automatic configure(input logic [1:0] ways, input logic [3:0] offset,
                            input logic [3:0] sets, input logic [15:0] seed);
      csr_write_enable <= 1'b1;
      csr_index <= CSR_WAYS_LOG2;
      csr_write_data <= CSR_W'(ways);
      @(negedge clock);
      csr_index <= CSR_OFFSET_BITS;
      csr_write_data <= CSR_W'(offset);
      @(negedge clock);
      csr_index <= CSR_SET_BITS;
      csr_write_data <= CSR_W'(sets);
      @(negedge clock);
      csr_index <= CSR_LFSR_SEED;
      csr_write_data <= CSR_W'(seed);
      @(negedge clock);
      csr_write_enable <= 1'b0;
      cur_offset = int'(offset);
      geometries++;
   endtask

   task automatic send_address(input logic [ADDR_W-1:0] address);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_address <= address;
      forever begin
         @(posedge clock);
         if (!req_stall) break;
      end
      @(negedge clock);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // mostly reuse of a small working set, some same-set conflicts, some fresh lines
   function automatic logic [ADDR_W-1:0] next_address();
      int                pick;
      int                slot;
      logic [ADDR_W-1:0] addr;
      pick = $urandom_range(99);
      slot = $urandom_range(15);
      if (pick < 60) begin
         addr = hot_pool[slot] ^ ($urandom & ((32'd1 << cur_offset) - 32'd1));
      end else if (pick < 82) begin
         addr = hot_pool[slot] ^ (ADDR_W'($urandom_range(1, 127)) << 25);
         hot_pool[slot] = addr;
      end else begin
         addr = $urandom;
         hot_pool[slot] = addr;
      end
      return addr;
   endfunction

   task automatic run_random(input int count);
      repeat (count) send_address(next_address());
   endtask

   initial begin
      foreach (hot_pool[i]) hot_pool[i] = $urandom;
      repeat (2) @(negedge clock);
      reset <= 1'b0;
      send_idle_pct = 16;
      rsp_stall_pct <= 87;

      // direct mapped at the reset geometry
      configure(2'd0, 4'd4, 4'd10, 16'd1);
      send_address(32'h0000_0000);
      send_address(32'h0000_0000);
      send_address(32'hFFFF_FFFF);
      send_address(32'hFFFF_FFFF);
      send_address(32'h0000_000F);

      // oversized associativity and set count, widest offset, zero seed
      wait_idle();
      configure(2'd3, 4'd15, 4'd15, 16'd0);
      send_address(32'h0000_0000);
      send_address(32'h8000_0000);
      send_address(32'h8000_7FFF);
      send_address(32'hFFFF_FFFF);
      send_address(32'h4000_0000);
      send_address(32'h0000_0000);

      // zero-width index, two ways, no offset
      wait_idle();
      configure(2'd1, 4'd0, 4'd0, 16'hFFFF);
      send_address(32'h0000_1234);
      send_address(32'h0000_1234);
      send_address(32'h0000_1235);
      send_address(32'hFFFF_FFFF);
      send_address(32'h0000_1234);

      // geometry change keeps old entries valid
      wait_idle();
      configure(2'd2, 4'd2, 4'd3, 16'h8000);
      send_address(32'h0000_1234);
      send_address(32'h0000_1235);

      // slow receiver, with one long hold-off to back up the request side
      wait_idle();
      send_idle_pct = 16;
      rsp_stall_pct <= 87;
      configure(2'd2, 4'd4, 4'd3, 16'($urandom_range(1, 65535)));
      pressure_req <= 1'b1;
      run_random(150);
      pressure_req <= 1'b0;
      run_random(150);

      // slow sender
      wait_idle();
      send_idle_pct = 87;
      rsp_stall_pct <= 16;
      configure(2'd1, 4'd0, 4'd10, 16'($urandom_range(1, 65535)));
      run_random(300);

      // back to back, with another hold-off
      wait_idle();
      send_idle_pct = 0;
      rsp_stall_pct <= 0;
      configure(2'd0, 4'd12, 4'd1, 16'($urandom_range(1, 65535)));
      pressure_req <= 1'b1;
      run_random(200);
      pressure_req <= 1'b0;

      wait_idle();
      configure(2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)),
                4'($urandom_range(0, 15)), 16'($urandom_range(0, 65535)));
      run_random(150);

      wait_idle();
      repeat (10) @(negedge clock);
      $display("checked %0d lookups (%0d hits) across %0d cache geometries,",
               lookups_checked, hits_checked, geometries);
      $display("with idle senders, stalling receivers and back-to-back traffic");
      if (mismatches == 0) begin
         $display("** cache_hit_miss_tag_store_unit: PASSED **");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("** cache_hit_miss_tag_store_unit: FAILED **");
      end
      $finish;
   end

endmodule
